/* src/lcd_mlt_pkg.sv */
// ----------------------------------------------------------------------------
// LCD mode and line timing: shared package
// Mode codes, timing lengths, line limits, configuration register indexes and the result type.
// ----------------------------------------------------------------------------
`default_nettype none

package lcd_mlt_pkg;

  // Display mode codes.
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // Cycle accumulator width and the length of each display mode.
  localparam int unsigned ACCUM_W = 10;
  localparam logic [ACCUM_W-1:0] LEN_OAM    = 10'd80;
  localparam logic [ACCUM_W-1:0] LEN_XFER   = 10'd172;
  localparam logic [ACCUM_W-1:0] LEN_HBLANK = 10'd204;
  localparam logic [ACCUM_W-1:0] LEN_LINE   = 10'd456;

  // Scan-line landmarks.
  localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;
  localparam logic [7:0] WRAP_LINE         = 8'd154;
  localparam logic [7:0] LINE_ZERO         = 8'd0;
  localparam logic [7:0] LINE_ONE          = 8'd1;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_COMPARE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HBLANK_IRQ_EN   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_VBLANK_STAT_EN  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OAM_IRQ_EN      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COINCIDE_IRQ_EN = 3'd4;

  // One result item.
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] line;
    logic       coincidence;
    logic       stat_irq;
    logic       vblank_irq;
  } result_t;

endpackage

`default_nettype wire

/* src/lcd_mode_line_timing.sv */
// ----------------------------------------------------------------------------
// LCD mode and line timing
// Tracks the display mode and scan line from the elapsed_cycles input, and raises
// the STAT and V-blank interrupt pulses.
// ----------------------------------------------------------------------------
//  Channel   Signals                                     Direction
//  input     in_valid, in_stall, elapsed_cycles          in (stall out)
//  output    out_valid, out_stall, mode, line, ...       out (stall in)
//  config    cfg_write_enable, cfg_index, cfg_data       in
//
//  An item passes through the input register and then the result register;
//  one item per cycle is sustained while the output does not stall. The
//  timing state is updated as the item moves into the result register.
//  Reset clears the timing state, the configuration registers and both
//  valid flags. A stall on the output holds the result and backs up into
//  in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_mode_line_timing (
  input  wire logic       clk,
  input  wire logic       rst,
  // Input channel.
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [5:0] elapsed_cycles,
  // Output channel.
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      mode,
  output logic [7:0]      line,
  output logic            coincidence,
  output logic            stat_irq,
  output logic            vblank_irq,
  // Configuration port.
  input  wire logic       cfg_write_enable,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  // Configuration registers.
  logic [7:0] line_compare;
  logic       hblank_irq_enable;
  logic       vblank_stat_irq_enable;
  logic       oam_irq_enable;
  logic       coincide_irq_enable;

  // Timing state.
  logic [lcd_mlt_pkg::ACCUM_W-1:0] cycle_accum;
  logic [1:0]                      mode_reg;
  logic [7:0]                      line_reg;
  logic                            coincide_reg;

  // Pipeline registers.
  logic                  pipe_valid;
  logic [5:0]            pipe_elapsed;
  lcd_mlt_pkg::result_t  result;

  // Next-state logic.
  logic [lcd_mlt_pkg::ACCUM_W-1:0] accum_sum;
  logic [lcd_mlt_pkg::ACCUM_W-1:0] cycle_accum_next;
  logic [1:0]                      mode_reg_next;
  logic [7:0]                      line_reg_next;
  logic                            coincide_reg_next;
  logic [7:0]                      line_inc;
  logic                            line_hit;
  logic                            zero_hit;
  logic                            stat_next;
  logic                            vbl_next;

  logic out_free;
  logic advance;

  // Handshake: the result register is free when empty or being emptied.
  assign out_free = !out_valid || !out_stall;
  assign advance  = pipe_valid && out_free;
  assign in_stall = pipe_valid && !out_free;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_compare           <= '0;
      hblank_irq_enable      <= 1'b0;
      vblank_stat_irq_enable <= 1'b0;
      oam_irq_enable         <= 1'b0;
      coincide_irq_enable    <= 1'b0;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        lcd_mlt_pkg::REG_LINE_COMPARE:    line_compare           <= cfg_data;
        lcd_mlt_pkg::REG_HBLANK_IRQ_EN:   hblank_irq_enable      <= cfg_data[0];
        lcd_mlt_pkg::REG_VBLANK_STAT_EN:  vblank_stat_irq_enable <= cfg_data[0];
        lcd_mlt_pkg::REG_OAM_IRQ_EN:      oam_irq_enable         <= cfg_data[0];
        lcd_mlt_pkg::REG_COINCIDE_IRQ_EN: coincide_irq_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (!in_stall) begin
      pipe_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      pipe_elapsed <= elapsed_cycles;
    end
  end

  // Mode sequencing: at most one mode change for each item.
  always_comb begin
    accum_sum         = cycle_accum + {4'd0, pipe_elapsed};
    line_inc          = line_reg + 8'd1;
    line_hit          = (line_inc == line_compare);
    zero_hit          = (line_compare == lcd_mlt_pkg::LINE_ZERO);
    cycle_accum_next  = accum_sum;
    mode_reg_next     = mode_reg;
    line_reg_next     = line_reg;
    coincide_reg_next = coincide_reg;
    stat_next         = 1'b0;
    vbl_next          = 1'b0;
    unique case (mode_reg)
      lcd_mlt_pkg::MODE_HBLANK: begin
        if (accum_sum >= lcd_mlt_pkg::LEN_HBLANK) begin
          cycle_accum_next  = accum_sum - lcd_mlt_pkg::LEN_HBLANK;
          line_reg_next     = line_inc;
          coincide_reg_next = line_hit;
          if (line_inc == lcd_mlt_pkg::FIRST_VBLANK_LINE) begin
            mode_reg_next = lcd_mlt_pkg::MODE_VBLANK;
            stat_next     = (line_hit && coincide_irq_enable) || vblank_stat_irq_enable;
            vbl_next      = 1'b1;
          end else begin
            mode_reg_next = lcd_mlt_pkg::MODE_OAM;
            stat_next     = (line_hit && coincide_irq_enable) || oam_irq_enable;
          end
        end
      end
      lcd_mlt_pkg::MODE_VBLANK: begin
        if (accum_sum >= lcd_mlt_pkg::LEN_LINE) begin
          cycle_accum_next = accum_sum - lcd_mlt_pkg::LEN_LINE;
          stat_next        = line_hit && coincide_irq_enable;
          if (line_inc == lcd_mlt_pkg::WRAP_LINE) begin
            // Past the last line: back to line 0, V-blank continues.
            line_reg_next     = lcd_mlt_pkg::LINE_ZERO;
            coincide_reg_next = line_hit;
          end else if (line_inc == lcd_mlt_pkg::LINE_ONE) begin
            // End of the extra line: line 0 is checked again, OAM starts.
            line_reg_next     = lcd_mlt_pkg::LINE_ZERO;
            mode_reg_next     = lcd_mlt_pkg::MODE_OAM;
            coincide_reg_next = zero_hit;
            stat_next         = stat_next || (zero_hit && coincide_irq_enable)
                                || oam_irq_enable;
          end else begin
            line_reg_next     = line_inc;
            coincide_reg_next = line_hit;
          end
        end
      end
      lcd_mlt_pkg::MODE_OAM: begin
        if (accum_sum >= lcd_mlt_pkg::LEN_OAM) begin
          cycle_accum_next = accum_sum - lcd_mlt_pkg::LEN_OAM;
          mode_reg_next    = lcd_mlt_pkg::MODE_XFER;
        end
      end
      lcd_mlt_pkg::MODE_XFER: begin
        if (accum_sum >= lcd_mlt_pkg::LEN_XFER) begin
          cycle_accum_next = accum_sum - lcd_mlt_pkg::LEN_XFER;
          mode_reg_next    = lcd_mlt_pkg::MODE_HBLANK;
          stat_next        = hblank_irq_enable;
        end
      end
      default: ;
    endcase
  end

  // Timing state update as an item moves to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_accum  <= '0;
      mode_reg     <= lcd_mlt_pkg::MODE_HBLANK;
      line_reg     <= '0;
      coincide_reg <= 1'b0;
    end else if (advance) begin
      cycle_accum  <= cycle_accum_next;
      mode_reg     <= mode_reg_next;
      line_reg     <= line_reg_next;
      coincide_reg <= coincide_reg_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pipe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.mode        <= mode_reg_next;
      result.line        <= line_reg_next;
      result.coincidence <= coincide_reg_next;
      result.stat_irq    <= stat_next;
      result.vblank_irq  <= vbl_next;
    end
  end

  assign mode        = result.mode;
  assign line        = result.line;
  assign coincidence = result.coincidence;
  assign stat_irq    = result.stat_irq;
  assign vblank_irq  = result.vblank_irq;

`ifndef SYNTHESIS
  // The stored line never reaches the wrap value.
  a_line_range: assert property (@(posedge clk) disable iff (rst)
    line_reg < lcd_mlt_pkg::WRAP_LINE)
    else $error("line register out of range");

  // The accumulator stays below the longest mode length.
  a_accum_range: assert property (@(posedge clk) disable iff (rst)
    cycle_accum < lcd_mlt_pkg::LEN_LINE)
    else $error("cycle accumulator out of range");

  // A V-blank pulse comes only on entering V-blank at its first line.
  a_vblank_entry: assert property (@(posedge clk) disable iff (rst)
    (out_valid && vblank_irq) |->
      (mode == lcd_mlt_pkg::MODE_VBLANK && line == lcd_mlt_pkg::FIRST_VBLANK_LINE))
    else $error("V-blank pulse outside V-blank entry");

  // The input is held off only while an item waits in the input register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (pipe_valid && out_valid && out_stall))
    else $error("input stalled without a blocked item");

  // An item in the input register with a free output reaches the output.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("item lost between stages");
`endif

endmodule

`default_nettype wire
